[rtl/sfcv_pkg.sv]
// Shared definitions for the sync frame checksum validator.
// Buffer geometry, sync constants, status and sequencer codes, helper functions.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package sfcv_pkg;

  // Receive buffer geometry.
  localparam int BufDepth = 128;
  localparam int BufAw    = $clog2(BufDepth);
  localparam int FillW    = $clog2(BufDepth + 1);

  // Frame framing constants.
  localparam logic [7:0] SyncByte0  = 8'h05;
  localparam logic [7:0] SyncByte1  = 8'h02;
  localparam logic [7:0] StrictType = 8'h01;
  localparam logic [7:0] SumSeedOne = 8'h55;
  // The second sum is seeded 0xAA, which is the first sum plus this offset.
  localparam logic [7:0] SumSeedGap = 8'h55;

  // Frame lengths per type byte.
  localparam logic [7:0] TypeLong   = 8'h01;
  localparam logic [7:0] TypeMid    = 8'h02;
  localparam logic [7:0] TypeShort  = 8'h03;
  localparam logic [7:0] TypeExtra  = 8'h04;
  localparam logic [6:0] LenLong    = 7'd66;
  localparam logic [6:0] LenMid     = 7'd23;
  localparam logic [6:0] LenShort   = 7'd7;
  localparam logic [6:0] LenExtra   = 7'd29;

  // Result status codes.
  typedef enum logic [2:0] {
    STAT_NO_SYNC    = 3'd0,
    STAT_INCOMPLETE = 3'd1,
    STAT_VALID      = 3'd2,
    STAT_BAD_TYPE   = 3'd3,
    STAT_BAD_SUM1   = 3'd4,
    STAT_BAD_SUM2   = 3'd5
  } status_e;

  // Sequencer states.
  typedef enum logic [3:0] {
    S_IDLE,
    S_TEST,
    S_RD0,
    S_RD1,
    S_RD2,
    S_CHK,
    S_SUM_RD,
    S_SUM_ACC,
    S_FINISH
  } seq_state_e;

  // Frame length for a type byte, zero for an unknown type.
  function automatic logic [6:0] length_of_type(input logic [7:0] t);
    logic [6:0] len;
    unique case (t)
      TypeLong:  len = LenLong;
      TypeMid:   len = LenMid;
      TypeShort: len = LenShort;
      TypeExtra: len = LenExtra;
      default:   len = 7'd0;
    endcase
    return len;
  endfunction

  // Circular pointer advance; the offset never exceeds the depth.
  function automatic logic [BufAw-1:0] ptr_add(input logic [BufAw-1:0] base,
                                                input logic [BufAw:0]   off);
    logic [BufAw:0] s;
    s = {1'b0, base} + off;
    if (s >= (BufAw+1)'(BufDepth)) begin
      s = s - (BufAw+1)'(BufDepth);
    end
    return s[BufAw-1:0];
  endfunction

endpackage

`default_nettype wire

[rtl/sfcv_ram.sv]
// Generic simple dual-port RAM with one write port and one registered read port.
// Width and depth are parameters; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

module sfcv_ram #(
  parameter int Width = 8,
  parameter int Depth = 128
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

[rtl/sync_frame_checksum_validator_top.sv]
// Top level of the sync frame checksum validator: sequencer, shared adder and buffer.
// Depends on sfcv_pkg and sfcv_ram.
//
// Usage:
// Received bytes enter on the rx channel (rx_valid_i / rx_ready_o / rx_byte_i), one
// per item. Each accepted item yields exactly one result item on the result channel
// (res_valid_o / res_ready_i) carrying status, frame type, frame length and the
// number of bytes dropped from the buffer head while handling that byte.
// The bytes sit in a 128-entry circular buffer held in a RAM with a registered
// read port. One sequencer walks it, and the checksum pass reads one frame byte at a
// time through one shared 8-bit adder. At each head position examined the sequencer
// tests the fill, then checks the two sync bytes and the type byte, and drops the
// head byte on the first mismatch; a search that runs out of bytes ends there. The
// checksum pass then reads each frame byte after the type byte, and the result
// register is loaded last. The next byte can be accepted in the cycle in which the
// result is first presented.
// The result sits in an output register; if the receiver stalls, the following
// result waits in the sequencer until the register frees. The configuration channel
// writes the strict type flag and is always ready. Reset empties the buffer.
`timescale 1ns / 1ps
`default_nettype none

module sync_frame_checksum_validator_top
  import sfcv_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  // Configuration write channel.
  input  wire logic       cfg_valid_i,
  output logic            cfg_ready_o,
  input  wire logic       cfg_data_i,
  // Input byte channel.
  input  wire logic       rx_valid_i,
  output logic            rx_ready_o,
  input  wire logic [7:0] rx_byte_i,
  // Result channel.
  output logic            res_valid_o,
  input  wire logic       res_ready_i,
  output logic [2:0]      status_o,
  output logic [7:0]      frame_type_o,
  output logic [6:0]      frame_length_o,
  output logic [7:0]      bytes_dropped_o
);

  // Control state.
  seq_state_e       state_q, state_d;
  logic [BufAw-1:0] head_q, head_d;
  logic [FillW-1:0] fill_q, fill_d;
  logic             strict_q;
  logic             out_valid_q, out_valid_d;

  // Working payload.
  status_e          stat_q, stat_d;
  logic [7:0]       ftype_q, ftype_d;
  logic [6:0]       flen_q, flen_d;
  logic [7:0]       drop_q, drop_d;
  logic [7:0]       acc_q, acc_d;
  logic [6:0]       idx_q, idx_d;

  // Output register payload.
  status_e          out_stat_q;
  logic [7:0]       out_ftype_q;
  logic [6:0]       out_flen_q;
  logic [7:0]       out_drop_q;

  // Buffer port signals.
  logic             ram_we;
  logic [BufAw-1:0] ram_waddr;
  logic [BufAw-1:0] ram_raddr;
  logic [7:0]       ram_rdata;

  // Derived values.
  logic             rx_fire;
  logic             buf_full;
  logic             out_free;
  logic [6:0]       type_len;
  logic [7:0]       sum_out;
  logic [7:0]       drop_inc;

  assign rx_ready_o  = (state_q == S_IDLE);
  assign rx_fire     = rx_valid_i && rx_ready_o;
  assign cfg_ready_o = 1'b1;
  assign buf_full    = (fill_q == FillW'(BufDepth));
  assign out_free    = !out_valid_q || res_ready_i;
  assign type_len    = length_of_type(ram_rdata);
  // Shared adder: accumulates frame bytes and forms the second seeded sum.
  assign sum_out     = acc_q + ((state_q == S_SUM_ACC && idx_q == flen_q - 7'd1) ?
                                SumSeedGap : ram_rdata);
  assign drop_inc    = (drop_q == 8'hFF) ? drop_q : drop_q + 8'd1;

  sfcv_ram #(
    .Width(8),
    .Depth(BufDepth)
  ) u_buf (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(rx_byte_i),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  // Next state of the sequencer.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (rx_fire) begin
          state_d = S_TEST;
        end
      end
      S_TEST: begin
        state_d = (fill_q < FillW'(3)) ? S_FINISH : S_RD0;
      end
      S_RD0: begin
        state_d = S_RD1;
      end
      S_RD1: begin
        state_d = (ram_rdata != SyncByte0) ? S_TEST : S_RD2;
      end
      S_RD2: begin
        state_d = (ram_rdata != SyncByte1) ? S_TEST : S_CHK;
      end
      S_CHK: begin
        if (strict_q && ram_rdata != StrictType) begin
          state_d = S_TEST;
        end else if (type_len == 7'd0 || fill_q < FillW'(type_len)) begin
          state_d = S_FINISH;
        end else begin
          state_d = S_SUM_RD;
        end
      end
      S_SUM_RD: begin
        state_d = S_SUM_ACC;
      end
      S_SUM_ACC: begin
        if (idx_q == flen_q - 7'd2 && ram_rdata != acc_q) begin
          state_d = S_FINISH;
        end else if (idx_q == flen_q - 7'd1) begin
          state_d = S_FINISH;
        end else begin
          state_d = S_SUM_RD;
        end
      end
      S_FINISH: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Datapath and buffer control for each state.
  always_comb begin
    head_d      = head_q;
    fill_d      = fill_q;
    stat_d      = stat_q;
    ftype_d     = ftype_q;
    flen_d      = flen_q;
    drop_d      = drop_q;
    acc_d       = acc_q;
    idx_d       = idx_q;
    out_valid_d = out_valid_q && !res_ready_i;
    ram_we      = 1'b0;
    ram_waddr   = ptr_add(head_q, (BufAw+1)'(fill_q));
    ram_raddr   = head_q;
    unique case (state_q)
      S_IDLE: begin
        // Append the byte; a full buffer loses its oldest byte, which is overwritten.
        if (rx_fire) begin
          ram_we  = 1'b1;
          stat_d  = STAT_NO_SYNC;
          ftype_d = 8'd0;
          flen_d  = 7'd0;
          if (buf_full) begin
            head_d = ptr_add(head_q, (BufAw+1)'(1));
            drop_d = 8'd1;
          end else begin
            fill_d = fill_q + FillW'(1);
            drop_d = 8'd0;
          end
        end
      end
      S_TEST: begin
        ram_raddr = head_q;
      end
      S_RD0: begin
        ram_raddr = head_q;
      end
      S_RD1: begin
        ram_raddr = ptr_add(head_q, (BufAw+1)'(1));
        if (ram_rdata != SyncByte0) begin
          head_d = ptr_add(head_q, (BufAw+1)'(1));
          fill_d = fill_q - FillW'(1);
          drop_d = drop_inc;
        end
      end
      S_RD2: begin
        ram_raddr = ptr_add(head_q, (BufAw+1)'(2));
        if (ram_rdata != SyncByte1) begin
          head_d = ptr_add(head_q, (BufAw+1)'(1));
          fill_d = fill_q - FillW'(1);
          drop_d = drop_inc;
        end
      end
      S_CHK: begin
        if (strict_q && ram_rdata != StrictType) begin
          head_d = ptr_add(head_q, (BufAw+1)'(1));
          fill_d = fill_q - FillW'(1);
          drop_d = drop_inc;
        end else begin
          ftype_d = ram_rdata;
          flen_d  = type_len;
          acc_d   = SumSeedOne + ram_rdata;
          idx_d   = 7'd3;
          if (type_len == 7'd0) begin
            stat_d = STAT_BAD_TYPE;
            head_d = ptr_add(head_q, (BufAw+1)'(1));
            fill_d = fill_q - FillW'(1);
            drop_d = drop_inc;
          end else if (fill_q < FillW'(type_len)) begin
            stat_d = STAT_INCOMPLETE;
          end
        end
      end
      S_SUM_RD: begin
        ram_raddr = ptr_add(head_q, (BufAw+1)'(idx_q));
      end
      S_SUM_ACC: begin
        idx_d = idx_q + 7'd1;
        if (idx_q == flen_q - 7'd2) begin
          // Stored first sum.
          if (ram_rdata != acc_q) begin
            stat_d = STAT_BAD_SUM1;
            head_d = ptr_add(head_q, (BufAw+1)'(1));
            fill_d = fill_q - FillW'(1);
            drop_d = drop_inc;
          end
        end else if (idx_q == flen_q - 7'd1) begin
          // Stored second sum; a good frame is consumed whole.
          if (ram_rdata != sum_out) begin
            stat_d = STAT_BAD_SUM2;
            head_d = ptr_add(head_q, (BufAw+1)'(1));
            fill_d = fill_q - FillW'(1);
            drop_d = drop_inc;
          end else begin
            stat_d = STAT_VALID;
            head_d = ptr_add(head_q, (BufAw+1)'(flen_q));
            fill_d = fill_q - FillW'(flen_q);
          end
        end else begin
          acc_d = sum_out;
        end
      end
      S_FINISH: begin
        if (out_free) begin
          out_valid_d = 1'b1;
        end
      end
      default: begin
        ram_raddr = head_q;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      head_q      <= '0;
      fill_q      <= '0;
      strict_q    <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      fill_q      <= fill_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        strict_q <= cfg_data_i;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    stat_q  <= stat_d;
    ftype_q <= ftype_d;
    flen_q  <= flen_d;
    drop_q  <= drop_d;
    acc_q   <= acc_d;
    idx_q   <= idx_d;
    if (state_q == S_FINISH && out_free) begin
      out_stat_q  <= stat_q;
      out_ftype_q <= ftype_q;
      out_flen_q  <= flen_q;
      out_drop_q  <= drop_q;
    end
  end

  // Result channel.
  assign res_valid_o     = out_valid_q;
  assign status_o        = out_stat_q;
  assign frame_type_o    = out_ftype_q;
  assign frame_length_o  = out_flen_q;
  assign bytes_dropped_o = out_drop_q;

endmodule

`default_nettype wire
